### src/ssr_pkg.sv
// Shared constants, register codes and request/result types for the substring replacer.
package ssr_pkg;

  // Longest pattern and replacement the datapath handles
  localparam int MaxPattern     = 8;
  localparam int MaxReplacement = 8;

  // Held bytes never exceed one less than the longest pattern
  localparam int WinDepth = MaxPattern - 1;
  localparam int FillW    = $clog2(MaxPattern);
  localparam int RepIdxW  = $clog2(MaxReplacement);

  // Length fields, byte counts per request and counters
  localparam int LenW = 4;
  localparam int CntW = 16;

  // Register port geometry: 64-bit registers at 8-byte strides
  localparam int DataW   = 64;
  localparam int AddrLsb = $clog2(DataW / 8);
  localparam int IdxW    = 3;
  localparam int AddrW   = IdxW + AddrLsb;

  typedef enum logic [IdxW-1:0] {
    RegPatternBytes     = 3'd0,
    RegPatternLength    = 3'd1,
    RegReplacementBytes = 3'd2,
    RegReplacementLen   = 3'd3,
    RegChangeLimit      = 3'd4,
    RegFirstOccurrence  = 3'd5,
    RegIgnoreCase       = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [63:0]     pattern_bytes;
    logic [LenW-1:0] pattern_length;
    logic [63:0]     replacement_bytes;
    logic [LenW-1:0] replacement_length;
    logic [CntW-1:0] change_limit;
    logic [CntW-1:0] first_occurrence;
    logic            ignore_case;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       last_of_string;
  } out_item_t;

  // Results of one request: window bytes first, then replacement bytes
  typedef struct packed {
    logic [MaxPattern-1:0][7:0] x;
    logic [LenW-1:0]            nx;
    logic [LenW-1:0]            n;
    logic                       last;
    logic                       present;
  } job_t;

  // Scan state after one request
  typedef struct packed {
    logic [WinDepth-1:0][7:0] win;
    logic [FillW-1:0]         fill;
    logic [CntW-1:0]          match_cnt;
    logic [CntW-1:0]          changes;
    logic                     limit;
    logic                     job_load;
  } step_t;

endpackage

### src/ssr_cfg.sv
// Register block of the substring replacer on the APB-style port.
module ssr_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ssr_pkg::AddrW-1:0] paddr,
  input  logic [ssr_pkg::DataW-1:0] pwdata,
  output logic [ssr_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output ssr_pkg::cfg_t             cfg_o,
  output logic                      pat_wr_o
);

  ssr_pkg::cfg_t     cfg_q, cfg_d;
  ssr_pkg::reg_idx_e idx;
  logic              wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = ssr_pkg::reg_idx_e'(paddr[ssr_pkg::AddrW-1:ssr_pkg::AddrLsb]);

  // Decode writes
  always_comb begin
    cfg_d    = cfg_q;
    pat_wr_o = 1'b0;
    if (wr) begin
      unique case (idx)
        ssr_pkg::RegPatternBytes: begin
          cfg_d.pattern_bytes = pwdata;
          pat_wr_o            = 1'b1;
        end
        ssr_pkg::RegPatternLength: begin
          cfg_d.pattern_length = pwdata[ssr_pkg::LenW-1:0];
          pat_wr_o             = 1'b1;
        end
        ssr_pkg::RegReplacementBytes: cfg_d.replacement_bytes = pwdata;
        ssr_pkg::RegReplacementLen:   cfg_d.replacement_length = pwdata[ssr_pkg::LenW-1:0];
        ssr_pkg::RegChangeLimit:      cfg_d.change_limit = pwdata[ssr_pkg::CntW-1:0];
        ssr_pkg::RegFirstOccurrence:  cfg_d.first_occurrence = pwdata[ssr_pkg::CntW-1:0];
        ssr_pkg::RegIgnoreCase: begin
          cfg_d.ignore_case = pwdata[0];
          pat_wr_o          = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pattern_bytes: '0, pattern_length: '0, replacement_bytes: '0,
                 replacement_length: '0, change_limit: '0,
                 first_occurrence: ssr_pkg::CntW'(1), ignore_case: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      ssr_pkg::RegPatternBytes:     prdata = cfg_q.pattern_bytes;
      ssr_pkg::RegPatternLength:    prdata = ssr_pkg::DataW'(cfg_q.pattern_length);
      ssr_pkg::RegReplacementBytes: prdata = cfg_q.replacement_bytes;
      ssr_pkg::RegReplacementLen:   prdata = ssr_pkg::DataW'(cfg_q.replacement_length);
      ssr_pkg::RegChangeLimit:      prdata = ssr_pkg::DataW'(cfg_q.change_limit);
      ssr_pkg::RegFirstOccurrence:  prdata = ssr_pkg::DataW'(cfg_q.first_occurrence);
      ssr_pkg::RegIgnoreCase:       prdata = ssr_pkg::DataW'(cfg_q.ignore_case);
      default:                      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### src/ssr_decide.sv
// Single-pass match decision for one request: results, next window and counters.
module ssr_decide (
  input  ssr_pkg::cfg_t                          cfg_i,
  input  logic [ssr_pkg::WinDepth-1:0][7:0]      win_i,
  input  logic [ssr_pkg::FillW-1:0]              fill_i,
  input  logic                                   stale_i,
  input  logic [ssr_pkg::CntW-1:0]               matches_i,
  input  logic [ssr_pkg::CntW-1:0]               changes_i,
  input  logic                                   limit_i,
  input  ssr_pkg::in_item_t                      item_i,
  output ssr_pkg::step_t                         step_o,
  output ssr_pkg::job_t                          job_o
);

  localparam int MaxPattern = ssr_pkg::MaxPattern;
  localparam int LenW       = ssr_pkg::LenW;
  localparam int FillW      = ssr_pkg::FillW;
  localparam int CntW       = ssr_pkg::CntW;

  // Upper-case ASCII letters when case is ignored
  function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
    logic [7:0] r;
    r = c;
    if (ic && c >= 8'h61 && c <= 8'h7a) r = c - 8'd32;
    return r;
  endfunction

  logic [MaxPattern-1:0][7:0] x, xf, pf;
  logic [MaxPattern-1:0]      m;
  logic [LenW-1:0]            plen, rlen, fw, flen, e, e_srch, nx, nr, n, held;
  logic [FillW-1:0]           base;
  logic [CntW-1:0]            first_eff;
  logic                       mb, limit, passall, full, hold0, skip, replace, last;

  assign last = item_i.end_of_string;

  // Held bytes followed by the new byte
  always_comb begin
    for (int i = 0; i < ssr_pkg::WinDepth; i++) begin
      if (FillW'(i) < fill_i)       x[i] = win_i[i];
      else if (FillW'(i) == fill_i) x[i] = item_i.data_byte;
      else                          x[i] = 8'h00;
    end
    x[MaxPattern-1] = (fill_i == FillW'(ssr_pkg::WinDepth)) ? item_i.data_byte : 8'h00;
    for (int i = 0; i < MaxPattern; i++) begin
      xf[i] = fold(x[i], cfg_i.ignore_case);
      pf[i] = fold(cfg_i.pattern_bytes[8*i +: 8], cfg_i.ignore_case);
    end
  end

  // Compare the tail from every start offset against the pattern head
  always_comb begin
    for (int s = 0; s < MaxPattern; s++) begin
      m[s] = 1'b1;
      for (int j = 0; j < MaxPattern; j++) begin
        if ((s + j) < MaxPattern && (s + j) <= int'(fill_i)) begin
          if (xf[s+j] != pf[j]) m[s] = 1'b0;
        end
      end
    end
  end

  // Clamp lengths and set up the decision
  assign plen = (cfg_i.pattern_length > LenW'(MaxPattern)) ? LenW'(MaxPattern)
                                                           : cfg_i.pattern_length;
  assign rlen = (cfg_i.replacement_length > LenW'(ssr_pkg::MaxReplacement))
                ? LenW'(ssr_pkg::MaxReplacement) : cfg_i.replacement_length;
  assign first_eff = (cfg_i.first_occurrence == '0) ? CntW'(1) : cfg_i.first_occurrence;

  // Stale bytes go out untouched; the scan then starts at the new byte
  assign base = stale_i ? fill_i : '0;
  assign fw   = LenW'(fill_i) + LenW'(1);
  assign flen = stale_i ? LenW'(1) : fw;
  assign mb   = stale_i ? m[fill_i] : m[0];

  assign limit   = limit_i || (cfg_i.change_limit != '0 && changes_i >= cfg_i.change_limit);
  assign passall = (plen == '0) || limit;
  assign full    = !passall && (flen == plen) && mb;
  assign hold0   = !passall && (flen < plen) && mb;
  assign skip    = full && (({1'b0, matches_i} + (CntW + 1)'(1)) < {1'b0, first_eff});
  assign replace = full && !skip;

  // First later offset whose tail still opens the pattern
  always_comb begin
    e_srch = fw;
    for (int s = MaxPattern - 1; s >= 1; s--) begin
      if (FillW'(s) > base && FillW'(s) <= fill_i && m[s]) e_srch = LenW'(s);
    end
  end

  assign e = passall ? fw : (hold0 ? LenW'(base) : e_srch);

  // Result counts
  assign nx   = replace ? LenW'(base) : (last ? fw : e);
  assign nr   = replace ? rlen : '0;
  assign n    = nx + nr;
  assign held = (replace || last) ? '0 : (fw - e);

  always_comb begin
    job_o.x       = x;
    job_o.nx      = nx;
    job_o.n       = n;
    job_o.last    = last;
    job_o.present = (n != '0);
  end

  // Shift the undecided bytes to the front of the window
  always_comb begin
    for (int i = 0; i < ssr_pkg::WinDepth; i++) begin
      step_o.win[i] = 8'h00;
      for (int s = 0; s < MaxPattern; s++) begin
        if (LenW'(s) == (e + LenW'(i))) step_o.win[i] = x[s];
      end
    end
    step_o.fill      = FillW'(held);
    step_o.match_cnt = last ? '0 : (skip ? matches_i + CntW'(1) : matches_i);
    if (last)                                  step_o.changes = '0;
    else if (replace && changes_i != '1)       step_o.changes = changes_i + CntW'(1);
    else                                       step_o.changes = changes_i;
    step_o.limit    = last ? 1'b0 : limit;
    step_o.job_load = (n != '0) || last;
  end

endmodule

### src/stream_substring_replace.sv
// Top level of the streaming substring replacer: scan state, result register and output drain.
//
//  channel   direction  handshake                   payload
//  in        sink       in_valid_i / in_stall_o     in_data_i  (data_byte, end_of_string)
//  out       source     out_valid_o / out_stall_i   out_data_o (out_byte, byte_present,
//                                                               last_of_string)
//  cfg       sink       psel / penable / pwrite     paddr, pwdata, prdata, pready
//
//  A request is decided in the cycle it is accepted and its results are loaded into the
//  result register; they leave one per cycle while out is not stalled, and a held byte with
//  no result loads nothing. The next request is accepted in the cycle the last result of
//  the previous one is taken. Reset clears the scan counters, fill and result register;
//  the held bytes need no clearing. A stall on out stops the drain and holds the input
//  side once the result register is full.
module stream_substring_replace (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  ssr_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output ssr_pkg::out_item_t        out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ssr_pkg::AddrW-1:0] paddr,
  input  logic [ssr_pkg::DataW-1:0] pwdata,
  output logic [ssr_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  ssr_pkg::cfg_t  cfg;
  ssr_pkg::step_t step;
  ssr_pkg::job_t  job_d, job_q;
  logic           pat_wr;

  logic [ssr_pkg::WinDepth-1:0][7:0] win_q;
  logic [ssr_pkg::FillW-1:0]         fill_q;
  logic [ssr_pkg::CntW-1:0]          matches_q, changes_q;
  logic                              limit_q, stale_q;
  logic                              job_valid_q;
  logic [ssr_pkg::LenW-1:0]          idx_q, rep_off;
  logic                              accept, take, final_res, done;

  ssr_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .pat_wr_o (pat_wr)
  );

  ssr_decide u_decide (
    .cfg_i     (cfg),
    .win_i     (win_q),
    .fill_i    (fill_q),
    .stale_i   (stale_q),
    .matches_i (matches_q),
    .changes_i (changes_q),
    .limit_i   (limit_q),
    .item_i    (in_data_i),
    .step_o    (step),
    .job_o     (job_d)
  );

  // Handshakes
  assign take       = job_valid_q && !out_stall_i;
  assign final_res  = !job_q.present || ((idx_q + ssr_pkg::LenW'(1)) == job_q.n);
  assign done       = take && final_res;
  assign in_stall_o = job_valid_q && !done;
  assign accept     = in_valid_i && !in_stall_o;

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      matches_q <= '0;
      changes_q <= '0;
      limit_q   <= 1'b0;
      stale_q   <= 1'b0;
    end else if (accept) begin
      fill_q    <= step.fill;
      matches_q <= step.match_cnt;
      changes_q <= step.changes;
      limit_q   <= step.limit;
      stale_q   <= 1'b0;
    end else if (pat_wr && fill_q != '0) begin
      stale_q <= 1'b1;
    end
  end

  // Held bytes
  always_ff @(posedge clk_i) begin
    if (accept) win_q <= step.win;
  end

  // Result register and drain position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (accept && step.job_load) begin
      job_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (done) begin
      job_valid_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + ssr_pkg::LenW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && step.job_load) job_q <= job_d;
  end

  // Select window byte or replacement byte
  assign rep_off = idx_q - job_q.nx;

  always_comb begin
    out_valid_o = job_valid_q;
    if (!job_q.present) begin
      out_data_o.out_byte = 8'h00;
    end else if (idx_q < job_q.nx) begin
      out_data_o.out_byte = job_q.x[idx_q[ssr_pkg::FillW-1:0]];
    end else begin
      out_data_o.out_byte =
        cfg.replacement_bytes[{rep_off[ssr_pkg::RepIdxW-1:0], 3'b000} +: 8];
    end
    out_data_o.byte_present   = job_q.present;
    out_data_o.last_of_string = job_q.last && final_res;
  end

endmodule

### src/ssr_checker.sv
// Port-level checks of the substring replacer, bound to the top level.
module ssr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input ssr_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ssr_pkg::out_item_t out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // An empty marker always closes a string
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_present |-> out_data_o.last_of_string)
    else $error("empty result not marked last");

  // The final byte of a string always yields a result
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.end_of_string |=> out_valid_o)
    else $error("end of string produced no result");

  // No request is taken while a result waits on a stalled output
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("request accepted behind a stalled result");

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (.*);
